@@ rtl/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg: shared definitions for the 3x3 matrix inverse
// Default widths and the cofactor source table.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ELEM         = 9;

    typedef logic [3:0] t_idx;

    // Adjugate entry k is a[s0]*a[s1] - a[s2]*a[s3], entries numbered row by row.
    localparam t_idx COF_SRC [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

@@ rtl/mi3_if.sv @@
// ----------------------------------------------------------------------------
// mi3_if: request channels of the 3x3 matrix inverse
// Input matrix channel and output inverse channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mi3_in_if #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

interface mi3_out_if #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] inv11, inv12, inv13, inv21, inv22, inv23;
    logic signed [DATA_WIDTH-1:0] inv31, inv32, inv33;
    logic                         singular;

    modport source (output valid, inv11, inv12, inv13, inv21, inv22, inv23,
                    inv31, inv32, inv33, singular, input ready);
    modport sink   (input valid, inv11, inv12, inv13, inv21, inv22, inv23,
                    inv31, inv32, inv33, singular, output ready);
endinterface

@@ rtl/matrix_inverse_3x3.sv @@
// Throughput: one matrix per cycle while the output is not stalled; the nine
// divider lanes take one quotient bit per stage, so their depth sets the latency but not the rate.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid flags; no data is cleared.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 matrix inverse by the adjugate
// Cofactors, determinant, nine divider lanes and a saturating merge stage.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mi3_in_if.sink    i_mat,
    mi3_out_if.source o_inv
);
    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int QB   = DW + 1;
    localparam int NV   = QB + 5;
    localparam int NE   = mi3_pkg::N_ELEM;
    localparam logic [QB-1:0] POS_LIM = {{(QB-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [QB-1:0] NEG_LIM = {{(QB-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    logic                   en;
    logic signed [DW-1:0]   a      [NE];
    logic signed [CW-1:0]   cof_c  [NE];
    logic signed [DW-1:0]   row    [3];
    logic signed [CW-1:0]   cof_d  [NE];
    logic signed [DETW-1:0] det;
    logic                   sing;
    logic [QB-1:0]          q      [NE];
    logic                   neg    [NE];
    logic                   big    [NE];
    logic [DW-1:0]          n_inv  [NE];

    logic [NV-1:0]          r_vld;
    logic [QB:0]            r_sing;
    logic                   r_out_valid;
    logic [DW-1:0]          r_inv  [NE];
    logic                   r_out_sing;

    assign en          = !r_out_valid || o_inv.ready;
    assign i_mat.ready = en;

    assign a[0] = i_mat.m11;  assign a[1] = i_mat.m12;  assign a[2] = i_mat.m13;
    assign a[3] = i_mat.m21;  assign a[4] = i_mat.m22;  assign a[5] = i_mat.m23;
    assign a[6] = i_mat.m31;  assign a[7] = i_mat.m32;  assign a[8] = i_mat.m33;

    mi3_cofactor #(.DATA_WIDTH(DW)) u_cof (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (a),
        .o_cof (cof_c),
        .o_row (row)
    );

    mi3_det #(.DATA_WIDTH(DW)) u_det (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cof  (cof_c),
        .i_row  (row),
        .o_cof  (cof_d),
        .o_det  (det),
        .o_sing (sing)
    );

    for (genvar k = 0; k < NE; k++) begin : g_lane
        mi3_div_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_cof (cof_d[k]),
            .i_det (det),
            .o_q   (q[k]),
            .o_neg (neg[k]),
            .o_big (big[k])
        );

        logic [QB-1:0] q_neg;
        always_comb begin
            q_neg = -q[k];
            if (neg[k]) begin
                n_inv[k] = (big[k] || q[k] > NEG_LIM) ? NEG_LIM[DW-1:0] : q_neg[DW-1:0];
            end else begin
                n_inv[k] = (big[k] || q[k] > POS_LIM) ? POS_LIM[DW-1:0] : q[k][DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_inv[k] <= r_sing[QB] ? '0 : n_inv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NV-2:0], i_mat.valid};
            r_out_valid <= r_vld[NV-1];
        end
    end

    // Singular flag leaves the determinant stage and rides beside the lanes.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing     <= {r_sing[QB-1:0], sing};
            r_out_sing <= r_sing[QB];
        end
    end

    assign o_inv.valid    = r_out_valid;
    assign o_inv.singular = r_out_sing;
    assign o_inv.inv11 = r_inv[0];  assign o_inv.inv12 = r_inv[1];
    assign o_inv.inv13 = r_inv[2];  assign o_inv.inv21 = r_inv[3];
    assign o_inv.inv22 = r_inv[4];  assign o_inv.inv23 = r_inv[5];
    assign o_inv.inv31 = r_inv[6];  assign o_inv.inv32 = r_inv[7];
    assign o_inv.inv33 = r_inv[8];

    a_sing_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inv.valid && o_inv.singular |-> o_inv.inv11 == '0 && o_inv.inv22 == '0
            && o_inv.inv33 == '0 && o_inv.inv12 == '0 && o_inv.inv21 == '0)
        else $error("singular result with nonzero entries");

    a_ready_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mat.ready == (!o_inv.valid || o_inv.ready))
        else $error("input ready disagrees with output register state");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_inv.valid && r_vld == '0)
        else $error("pipeline not empty after reset");

    a_hold_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_inv.ready |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");
endmodule

@@ rtl/mi3_cofactor.sv @@
// ----------------------------------------------------------------------------
// mi3_cofactor: cofactor stages
// Eighteen products in one stage, nine exact differences in the next.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [DATA_WIDTH-1:0]   i_a   [mi3_pkg::N_ELEM],
    output logic signed [2*DATA_WIDTH:0]   o_cof [mi3_pkg::N_ELEM],
    output logic signed [DATA_WIDTH-1:0]   o_row [3]
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = PW + 1;

    logic signed [PW-1:0]         r_p1   [mi3_pkg::N_ELEM];
    logic signed [PW-1:0]         r_p2   [mi3_pkg::N_ELEM];
    logic signed [CW-1:0]         r_cof  [mi3_pkg::N_ELEM];
    logic signed [DATA_WIDTH-1:0] r_row1 [3];
    logic signed [DATA_WIDTH-1:0] r_row2 [3];

    for (genvar k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p1[k]  <= i_a[mi3_pkg::COF_SRC[k][0]] * i_a[mi3_pkg::COF_SRC[k][1]];
                r_p2[k]  <= i_a[mi3_pkg::COF_SRC[k][2]] * i_a[mi3_pkg::COF_SRC[k][3]];
                r_cof[k] <= CW'(r_p1[k]) - CW'(r_p2[k]);
            end
        end
        assign o_cof[k] = r_cof[k];
    end

    for (genvar j = 0; j < 3; j++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_row1[j] <= i_a[j];
                r_row2[j] <= r_row1[j];
            end
        end
        assign o_row[j] = r_row2[j];
    end
endmodule

@@ rtl/mi3_det.sv @@
// ----------------------------------------------------------------------------
// mi3_det: determinant stages
// Expansion along the top row; each product is split into a low and a
// high half of the cofactor; each multiplier is a word by a word and one bit.
// ----------------------------------------------------------------------------
module mi3_det #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [2*DATA_WIDTH:0]   i_cof [mi3_pkg::N_ELEM],
    input  logic signed [DATA_WIDTH-1:0]   i_row [3],
    output logic signed [2*DATA_WIDTH:0]   o_cof [mi3_pkg::N_ELEM],
    output logic signed [3*DATA_WIDTH+2:0] o_det,
    output logic                           o_sing
);
    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int LPW  = 2 * DW + 1;
    localparam int HPW  = 2 * DW + 1;

    logic signed [LPW-1:0]  r_lo   [3];
    logic signed [HPW-1:0]  r_hi   [3];
    logic signed [CW-1:0]   r_cof3 [mi3_pkg::N_ELEM];
    logic signed [CW-1:0]   r_cof4 [mi3_pkg::N_ELEM];
    logic signed [DETW-1:0] r_det;
    logic signed [DETW-1:0] n_det;
    logic                   r_sing;

    for (genvar j = 0; j < 3; j++) begin : g_pp
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[j] <= i_row[j] * $signed({1'b0, i_cof[3*j][DW-1:0]});
                r_hi[j] <= i_row[j] * $signed(i_cof[3*j][CW-1:DW]);
            end
        end
    end

    always_comb begin
        n_det = DETW'(r_lo[0]) + DETW'(r_lo[1]) + DETW'(r_lo[2])
              + ((DETW'(r_hi[0]) + DETW'(r_hi[1]) + DETW'(r_hi[2])) <<< DW);
    end

    for (genvar k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cof3[k] <= i_cof[k];
                r_cof4[k] <= r_cof3[k];
            end
        end
        assign o_cof[k] = r_cof4[k];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det  <= n_det;
            r_sing <= (n_det == '0);
        end
    end

    assign o_det  = r_det;
    assign o_sing = r_sing;
endmodule

@@ rtl/mi3_div_lane.sv @@
// ----------------------------------------------------------------------------
// mi3_div_lane: one divider lane
// Signed quotient of a scaled cofactor by the determinant: one prepare stage,
// then one restoring step per stage for each quotient bit.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [2*DATA_WIDTH:0]   i_cof,
    input  logic signed [3*DATA_WIDTH+2:0] i_det,
    output logic [DATA_WIDTH:0]            o_q,
    output logic                           o_neg,
    output logic                           o_big
);
    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int QB   = DW + 1;
    localparam int NUMW = CW + 2 * FRAC_BITS;
    localparam int HW   = NUMW - QB;
    localparam int CMPW = (HW > DETW) ? HW : DETW;

    logic [CW-1:0]   mag;
    logic [NUMW-1:0] num;
    logic [DETW-1:0] dabs;

    logic [DETW-1:0] r_rem  [QB+1];
    logic [QB-1:0]   r_nq   [QB+1];
    logic [DETW-1:0] r_dabs [QB+1];
    logic            r_neg  [QB+1];
    logic            r_big  [QB+1];

    always_comb begin
        mag  = i_cof[CW-1] ? CW'(-i_cof) : CW'(i_cof);
        num  = NUMW'(mag) << (2 * FRAC_BITS);
        dabs = i_det[DETW-1] ? DETW'(-i_det) : DETW'(i_det);
    end

    // A high part already at or above the divisor means the quotient
    // cannot fit and the result saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DETW'(num[NUMW-1:QB]);
            r_nq[0]   <= num[QB-1:0];
            r_dabs[0] <= dabs;
            r_neg[0]  <= i_cof[CW-1] ^ i_det[DETW-1];
            r_big[0]  <= CMPW'(num[NUMW-1:QB]) >= CMPW'(dabs);
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
        logic [DETW:0] t;
        logic          ge;
        always_comb begin
            t  = {r_rem[s], r_nq[s][QB-1]};
            ge = t >= {1'b0, r_dabs[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= ge ? DETW'(t - {1'b0, r_dabs[s]}) : DETW'(t);
                r_nq[s+1]   <= {r_nq[s][QB-2:0], ge};
                r_dabs[s+1] <= r_dabs[s];
                r_neg[s+1]  <= r_neg[s];
                r_big[s+1]  <= r_big[s];
            end
        end
    end

    assign o_q   = r_nq[QB];
    assign o_neg = r_neg[QB];
    assign o_big = r_big[QB];
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the 3x3 matrix inverse
// Streams matrices through the block with random gaps on both channels and
// checks every inverse, field by field, against a wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int N_RANDOM  = 700;
    localparam int IDLE_LIMIT = 4000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [DW-1:0] e [mi3_pkg::N_ELEM];
    } t_mat;

    typedef struct {
        logic signed [DW-1:0] e [mi3_pkg::N_ELEM];
        logic                 singular;
    } t_inv;

    class inverse_scoreboard;
        t_inv pending_inv [$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function t_inv invert(t_mat m);
            t_wide a [mi3_pkg::N_ELEM];
            t_wide cof [mi3_pkg::N_ELEM];
            t_wide det, dmag, num, quot;
            t_wide pos_lim, neg_lim;
            t_inv  r;
            logic  neg;
            pos_lim = (t_wide'(1) <<< (DW - 1)) - 1;
            neg_lim = t_wide'(1) <<< (DW - 1);
            for (int k = 0; k < mi3_pkg::N_ELEM; k++) a[k] = t_wide'(m.e[k]);
            for (int k = 0; k < mi3_pkg::N_ELEM; k++)
                cof[k] = a[mi3_pkg::COF_SRC[k][0]] * a[mi3_pkg::COF_SRC[k][1]]
                       - a[mi3_pkg::COF_SRC[k][2]] * a[mi3_pkg::COF_SRC[k][3]];
            det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
            r.singular = (det == 0);
            dmag = (det < 0) ? -det : det;
            for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
                if (r.singular) begin
                    r.e[k] = '0;
                end else begin
                    neg  = (cof[k] < 0) != (det < 0);
                    num  = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< (2 * FB);
                    quot = t_wide'($unsigned(num) / $unsigned(dmag));
                    if (neg) begin
                        if (quot > neg_lim) quot = neg_lim;
                        r.e[k] = DW'(-quot);
                    end else begin
                        if (quot > pos_lim) quot = pos_lim;
                        r.e[k] = DW'(quot);
                    end
                end
            end
            return r;
        endfunction

        function void note_matrix(t_mat m);
            pending_inv.push_back(invert(m));
        endfunction

        function void check_inverse(t_inv got);
            t_inv want;
            if (pending_inv.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                errors++;
                return;
            end
            want = pending_inv.pop_front();
            for (int k = 0; k < mi3_pkg::N_ELEM; k++)
                if (got.e[k] !== want.e[k]) begin
                    $display("%0t: inv%0d%0d expected %h actual %h", $time,
                             k / 3 + 1, k % 3 + 1, want.e[k], got.e[k]);
                    errors++;
                end
            if (got.singular !== want.singular) begin
                $display("%0t: singular expected %b actual %b", $time,
                         want.singular, got.singular);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic quiet;
    int   idle_cycles;

    mi3_in_if  #(.DATA_WIDTH(DW)) mat_if ();
    mi3_out_if #(.DATA_WIDTH(DW)) inv_if ();

    matrix_inverse_3x3 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_if),
        .o_inv   (inv_if)
    );

    inverse_scoreboard sb = new();

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (quiet) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic signed [DW-1:0] near(int span);
        return $signed(DW'($urandom_range(0, 2 * span))) - span;
    endfunction

    function automatic t_mat make_mat(logic signed [DW-1:0] v0, v1, v2, v3, v4,
                                      v5, v6, v7, v8);
        t_mat m;
        m.e = '{v0, v1, v2, v3, v4, v5, v6, v7, v8};
        return m;
    endfunction

    function automatic t_mat random_mat();
        t_mat m;
        int   pick, span;
        pick = $urandom_range(0, 9);
        span = (pick < 5) ? 32'h40000 : 32'h400;
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
            m.e[k] = (pick >= 8) ? $signed($urandom()) : near(span);
        if (pick == 7) begin
            // one row a copy of another, so the determinant vanishes
            for (int k = 0; k < 3; k++) m.e[6 + k] = m.e[k];
        end else if (pick == 6) begin
            // strong diagonal gives a well-conditioned matrix
            m.e[0] = m.e[0] + 32'h80000;
            m.e[4] = m.e[4] - 32'h80000;
            m.e[8] = m.e[8] + 32'h80000;
        end
        return m;
    endfunction

    task automatic send_matrix(t_mat m);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            mat_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        mat_if.m11 <= m.e[0]; mat_if.m12 <= m.e[1]; mat_if.m13 <= m.e[2];
        mat_if.m21 <= m.e[3]; mat_if.m22 <= m.e[4]; mat_if.m23 <= m.e[5];
        mat_if.m31 <= m.e[6]; mat_if.m32 <= m.e[7]; mat_if.m33 <= m.e[8];
        mat_if.valid <= 1'b1;
        do @(posedge i_clk); while (!(mat_if.valid && mat_if.ready));
    endtask

    // Accepted requests on both channels, sampled before the edge's updates.
    always @(posedge i_clk) begin
        t_mat m;
        t_inv r;
        if (i_rst_n && mat_if.valid && mat_if.ready) begin
            m = make_mat(mat_if.m11, mat_if.m12, mat_if.m13, mat_if.m21, mat_if.m22,
                         mat_if.m23, mat_if.m31, mat_if.m32, mat_if.m33);
            sb.note_matrix(m);
        end
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            r.e = '{inv_if.inv11, inv_if.inv12, inv_if.inv13, inv_if.inv21,
                    inv_if.inv22, inv_if.inv23, inv_if.inv31, inv_if.inv32,
                    inv_if.inv33};
            r.singular = inv_if.singular;
            sb.check_inverse(r);
        end
    end

    // Result side back-pressure.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            inv_if.ready <= 1'b0;
        end else if (inv_if.valid && inv_if.ready) begin
            stall_left = draw_gap();
            if (stall_left > 0) inv_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            inv_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    localparam logic signed [DW-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [DW-1:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] MINV = 32'sh8000_0000;

    initial begin
        quiet          = 1'b0;
        i_rst_n       <= 1'b0;
        mat_if.valid  <= 1'b0;
        mat_if.m11 <= '0; mat_if.m12 <= '0; mat_if.m13 <= '0;
        mat_if.m21 <= '0; mat_if.m22 <= '0; mat_if.m23 <= '0;
        mat_if.m31 <= '0; mat_if.m32 <= '0; mat_if.m33 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_matrix(make_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(make_mat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        send_matrix(make_mat(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
        send_matrix(make_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
        send_matrix(make_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
        send_matrix(make_mat(MINV, 0, 0, 0, MAXV, 0, 0, 0, MINV));
        // Tiny determinant: the inverse saturates both ways.
        send_matrix(make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(make_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(make_mat(1, MAXV, MINV, 0, 1, 0, MAXV, 0, 1));
        send_matrix(make_mat(2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, 3 * ONE));
        send_matrix(make_mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                             7 * ONE, 8 * ONE, 10 * ONE));
        // Rank-deficient: rows in arithmetic progression.
        send_matrix(make_mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                             7 * ONE, 8 * ONE, 9 * ONE));
        send_matrix(make_mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
        send_matrix(make_mat(MAXV, MINV, MAXV, MINV, MAXV, MINV, 1, -1, 0));
        send_matrix(make_mat(-ONE, 3, -5, 7, -ONE, 11, 13, -17, -ONE));
        send_matrix(make_mat(32'sh5555_5555, 32'shaaaa_aaaa, 1, -1, 32'sh5555_5555,
                             32'shaaaa_aaaa, 2, 3, 32'sh5555_5555));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 40) quiet = 1'b1;
            if (n % 100 == 70) quiet = 1'b0;
            send_matrix(random_mat());
        end
        mat_if.valid <= 1'b0;
        quiet = 1'b0;

        while (sb.pending_inv.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && !inv_if.valid)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ matrix_inverse_3x3.f @@
rtl/mi3_pkg.sv
rtl/mi3_if.sv
rtl/mi3_cofactor.sv
rtl/mi3_det.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3.sv
bench/tb_top.sv
